// ===== sv/ecnc_pkg.sv =====
// Shared types and field widths for the edge-clamped normalized convolver.
`default_nettype none
package ecnc_pkg;
    localparam int TAP_IDX_W = 6;
    localparam int COEF_W    = 18;
    localparam int SAMPLE_W  = 24;
    localparam int POS_W     = 12;
    localparam int CFG_W     = 6;

    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [TAP_IDX_W-1:0]       tap_index;
        logic [COEF_W-1:0]          coef;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_item;
endpackage
`default_nettype wire

// ===== sv/ecnc_front.sv =====
// Input stage: accept stream transfers, classify them and drop bad tap writes.
`default_nettype none
module ecnc_front import ecnc_pkg::*; #(
    parameter int MAX_TAPS = 63
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,
    input  wire         s_axis_tuser,
    input  wire         s_axis_tlast,
    output logic        o_push,
    output t_item       o_item,
    input  wire         i_full
);
    t_item n_item;

    always_comb begin
        n_item.kind      = s_axis_tuser;
        n_item.tap_index = s_axis_tdata[5:0];
        n_item.coef      = s_axis_tdata[23:6];
        n_item.sample    = s_axis_tdata[47:24];
        n_item.last      = s_axis_tlast & s_axis_tuser;
    end

    assign s_axis_tready = !i_full && i_rst_n;
    assign o_item        = n_item;
    assign o_push        = s_axis_tvalid && s_axis_tready &&
                           (n_item.kind == KIND_SAMPLE ||
                            32'(n_item.tap_index) < MAX_TAPS);
endmodule
`default_nettype wire

// ===== sv/ecnc_queue.sv =====
// Two-entry queue between front and back.
`default_nettype none
module ecnc_queue import ecnc_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  wire   i_pop
);
    t_item r_mem [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/ecnc_back.sv =====
// Execution stage: tap and sample stores, serial MAC, serial divider, output register.
`default_nettype none
module ecnc_back import ecnc_pkg::*; #(
    parameter int MAX_TAPS = 63,
    parameter int MAX_LEN  = 4096
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [CFG_W-1:0]    i_tap_count,
    input  wire                 i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [SAMPLE_W-1:0] o_smoothed,
    output logic [POS_W-1:0]    o_position,
    output logic                o_zero_sum,
    output logic                o_last
);
    localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int IW    = CW + 2;
    localparam int PW    = COEF_W + SAMPLE_W + 1;
    localparam int AW    = PW + $clog2(MAX_TAPS + 1) + 1;
    localparam int SW    = COEF_W + $clog2(MAX_TAPS + 1);
    localparam int NW    = AW + 1;
    localparam int DW    = SW + 1;
    localparam int DCW   = $clog2(NW + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] r_state;

    logic [COEF_W-1:0]          r_tap_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] r_win_mem [MAX_TAPS];

    logic signed [SAMPLE_W-1:0] r_first;
    logic [CW-1:0]  r_cnt, r_optr;
    logic [5:0]     r_ktaps;
    logic [TW-1:0]  r_wptr, r_wlast;
    logic           r_last;

    logic [6:0]     r_j;
    logic           r_issue;
    logic signed [IW-1:0] r_idx;
    logic [TW-1:0]  r_slot;
    logic           r_v1, r_neg1, r_v2;
    logic [COEF_W-1:0]          r_tap_rd, r_w2;
    logic signed [SAMPLE_W-1:0] r_win_rd;
    logic signed [PW-1:0]       r_prod;
    logic signed [AW-1:0]       r_acc;
    logic [SW-1:0]  r_sum;

    logic [NW-1:0]  r_num, r_quo;
    logic [DW:0]    r_rem;
    logic [DCW-1:0] r_dcnt;
    logic           r_negq;

    logic [5:0]     w_eff;
    logic [5:0]     w_half;
    logic [CW:0]    w_n;
    logic           w_emit;
    logic signed [IW-1:0] w_nm1, w_start, w_dist, w_idx_n;
    logic signed [TW+1:0] w_slot0;
    logic [AW-1:0]  w_mag;
    logic [DW:0]    w_rem_sh, w_den;

    always_comb begin
        w_eff = i_tap_count;
        if (32'(w_eff) > MAX_TAPS) w_eff = 6'(MAX_TAPS);
        if (!w_eff[0] && w_eff != 6'd0) w_eff = w_eff - 6'd1;
    end

    assign w_half  = {1'b0, r_ktaps[5:1]};
    assign w_n     = (CW+1)'(r_cnt);
    assign w_emit  = r_last ? ((CW+1)'(r_optr) < w_n)
                            : ((CW+1)'(r_optr) + (CW+1)'(w_half) < w_n);
    assign w_nm1   = IW'(w_n) - IW'(1);
    assign w_start = IW'(r_optr) + IW'(w_half);
    assign w_dist  = w_nm1 - w_start;
    assign w_slot0 = (TW+2)'(r_wlast) - (TW+2)'(w_dist);
    assign w_idx_n = r_idx - IW'(1);
    assign w_mag   = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
    assign w_den   = (DW+1)'({r_sum, 1'b0});
    assign w_rem_sh = {r_rem[DW-1:0], r_num[NW-1]};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) begin
            if (i_q_item.kind == KIND_TAP) begin
                r_tap_mem[TW'(i_q_item.tap_index)] <= i_q_item.coef;
            end else begin
                r_win_mem[r_wptr] <= i_q_item.sample;
            end
        end
        r_tap_rd <= r_tap_mem[TW'(r_j)];
        r_win_rd <= r_win_mem[r_slot];
    end

    assign o_q_pop = r_state == ST_IDLE && i_q_valid;

    always_ff @(posedge i_clk) begin
        r_neg1 <= r_idx < 0;
        r_w2   <= r_tap_rd;
        r_prod <= PW'(signed'({1'b0, r_tap_rd})) * PW'(r_neg1 ? r_first : r_win_rd);
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_optr  <= '0;
            r_wptr  <= '0;
            r_wlast <= '0;
            r_ktaps <= 6'd1;
            r_last  <= 1'b0;
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            if (o_valid && i_ready && r_state != ST_OUT) o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid && i_q_item.kind == KIND_SAMPLE) begin
                        if (r_cnt == '0) begin
                            r_first <= i_q_item.sample;
                            r_ktaps <= w_eff;
                            r_optr  <= '0;
                        end
                        r_wlast <= r_wptr;
                        r_wptr  <= (32'(r_wptr) == MAX_TAPS - 1) ? '0 : r_wptr + TW'(1);
                        r_cnt   <= r_cnt + CW'(1);
                        r_last  <= i_q_item.last || (32'(r_cnt) + 1 >= MAX_LEN);
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (w_emit) begin
                        r_j     <= '0;
                        r_idx   <= w_start;
                        r_slot  <= (w_dist <= 0) ? r_wlast :
                                   (w_slot0 < 0) ? TW'(w_slot0 + (TW+2)'(MAX_TAPS))
                                                 : TW'(w_slot0);
                        r_issue <= r_ktaps != 6'd0;
                        r_acc   <= '0;
                        r_sum   <= '0;
                        r_state <= ST_MAC;
                    end else begin
                        if (r_last) begin
                            r_cnt  <= '0;
                            r_optr <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_MAC: begin
                    if (r_issue) begin
                        r_j   <= r_j + 7'd1;
                        r_idx <= w_idx_n;
                        if (w_idx_n < w_nm1) begin
                            r_slot <= (r_slot == '0) ? TW'(MAX_TAPS - 1) : r_slot - TW'(1);
                        end
                        if (r_j + 7'd1 == 7'(r_ktaps)) r_issue <= 1'b0;
                    end
                    if (r_v2) begin
                        r_acc <= r_acc + AW'(r_prod);
                        r_sum <= r_sum + SW'(r_w2);
                    end
                    if (!r_issue && !r_v1 && !r_v2) begin
                        r_negq  <= r_acc[AW-1];
                        r_num   <= NW'({w_mag, 1'b0}) + NW'(r_sum);
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_dcnt  <= DCW'(NW);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_dcnt != '0) begin
                        r_num  <= {r_num[NW-2:0], 1'b0};
                        if (w_rem_sh >= w_den) begin
                            r_rem <= w_rem_sh - w_den;
                            r_quo <= {r_quo[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rem_sh;
                            r_quo <= {r_quo[NW-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt - DCW'(1);
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid    <= 1'b1;
                        o_position <= POS_W'(r_optr);
                        o_zero_sum <= r_sum == '0;
                        o_last     <= r_last && ((CW+1)'(r_optr) + 1 == w_n);
                        if (r_sum == '0) begin
                            o_smoothed <= '0;
                        end else if (r_negq) begin
                            o_smoothed <= (r_quo > NW'(8388608)) ? 24'h800000
                                        : SAMPLE_W'(-r_quo);
                        end else begin
                            o_smoothed <= (r_quo > NW'(8388607)) ? 24'h7FFFFF
                                        : SAMPLE_W'(r_quo);
                        end
                        r_optr  <= r_optr + CW'(1);
                        r_state <= ST_CHECK;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/edge_clamped_normalized_convolver.sv =====
// Top level: edge-clamped normalized FIR smoother for one spectrum column.
// Tap write: one back-end cycle once queued. Sample: 2 cycles plus, per output
// it releases, one check cycle, K + 3 cycles of serial multiply-accumulate
// (K = effective tap count, one tap a cycle), 52 cycles of the bit-serial
// divider and one output cycle, so K + 57 while the output side is ready.
// Synchronous active-low reset clears control state; tap store is undefined.
`default_nettype none
module edge_clamped_normalized_convolver import ecnc_pkg::*; #(
    parameter int MAX_TAPS = 63,
    parameter int MAX_LEN  = 4096
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire  [CFG_W-1:0] i_cfg_data,    // tap_count
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire  [47:0]      s_axis_tdata,  // tap_index, coef, sample
    input  wire              s_axis_tuser,  // cmd
    input  wire              s_axis_tlast,  // last_in
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // smoothed, position, zero pad
    output logic             m_axis_tuser,  // zero_sum
    output logic             m_axis_tlast   // last_out
);
    logic [CFG_W-1:0] r_tap_count;
    logic  w_push, w_full, w_qvalid, w_pop;
    t_item w_fitem, w_qitem;
    logic [SAMPLE_W-1:0] w_sm;
    logic [POS_W-1:0]    w_pos;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_tap_count <= i_cfg_data;
        end
    end

    ecnc_front #(.MAX_TAPS(MAX_TAPS)) u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .s_axis_tlast,
        .o_push(w_push), .o_item(w_fitem), .i_full(w_full)
    );

    ecnc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_item(w_fitem), .o_full(w_full),
        .o_valid(w_qvalid), .o_item(w_qitem), .i_pop(w_pop)
    );

    ecnc_back #(.MAX_TAPS(MAX_TAPS), .MAX_LEN(MAX_LEN)) u_back (
        .i_clk, .i_rst_n, .i_tap_count(r_tap_count),
        .i_q_valid(w_qvalid), .i_q_item(w_qitem), .o_q_pop(w_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_smoothed(w_sm), .o_position(w_pos),
        .o_zero_sum(m_axis_tuser), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_pos, w_sm};
endmodule
`default_nettype wire

// ===== test/edge_clamped_normalized_convolver_test.sv =====
// Self-checking testbench for the edge-clamped normalized convolver: random streams, scoreboard.
`default_nettype none
module edge_clamped_normalized_convolver_test import ecnc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS  = 63;
    localparam int COLMAX = 4096;

    typedef struct {
        logic [SAMPLE_W-1:0] smoothed;
        logic [POS_W-1:0]    position;
        logic                zero_sum;
        logic                last_out;
    } t_smooth;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tready = 1'b0;
    logic o_cfg_ready, s_axis_tready, m_axis_tvalid, m_axis_tuser, m_axis_tlast;
    logic [39:0] m_axis_tdata;

    edge_clamped_normalized_convolver DUT (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [COEF_W-1:0]   kernel [NTAPS];
    logic [SAMPLE_W-1:0] window [NTAPS];
    logic [SAMPLE_W-1:0] edge_lo;
    int unsigned col_len, out_next, col_k, tap_count_reg;
    t_smooth expected_q[$];
    t_item   pending_q[$];
    int mismatches = 0;
    int unsigned cycles = 0;
    int quiet_in = 0, quiet_out = 0;
    bit stim_done = 0;

    function automatic longint fetch_sample(longint idx, int unsigned n);
        if (idx < 0) return longint'($signed(edge_lo));
        if (idx >= n) idx = n - 1;
        return longint'($signed(window[idx % NTAPS]));
    endfunction

    function automatic void push_smoothed(int unsigned p, int unsigned n, bit last);
        longint acc, y;
        longint unsigned s, mag, q;
        t_smooth r;
        acc = 0;
        s = 0;
        for (int j = 0; j < col_k; j++) begin
            acc += longint'(kernel[j]) * fetch_sample(longint'(p) + col_k / 2 - j, n);
            s += kernel[j];
        end
        if (s == 0) begin
            y = 0;
        end else begin
            mag = (acc < 0) ? -acc : acc;
            q = (2 * mag + s) / (2 * s);
            if (acc < 0) y = (q > 8388608) ? -8388608 : -longint'(q);
            else y = (q > 8388607) ? 8388607 : longint'(q);
        end
        r.smoothed = y[SAMPLE_W-1:0];
        r.position = p[POS_W-1:0];
        r.zero_sum = (s == 0);
        r.last_out = last;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_item(t_item it);
        int unsigned n;
        bit last;
        if (it.kind == KIND_TAP) begin
            if (it.tap_index < NTAPS) kernel[it.tap_index] = it.coef;
            return;
        end
        last = it.last;
        if (col_len == 0) begin
            edge_lo = it.sample;
            col_k = tap_count_reg;
            if (col_k % 2 == 0 && col_k > 0) col_k--;
            out_next = 0;
        end
        window[col_len % NTAPS] = it.sample;
        col_len++;
        n = col_len;
        if (n >= COLMAX) last = 1;
        if (!last) begin
            while (out_next + col_k / 2 < n) begin
                push_smoothed(out_next, n, 0);
                out_next++;
            end
        end else begin
            while (out_next < n) begin
                push_smoothed(out_next, n, out_next + 1 == n);
                out_next++;
            end
            col_len = 0;
            out_next = 0;
        end
    endfunction

    function automatic t_item tap_item(int idx, int c);
        t_item it;
        it = '0;
        it.kind = KIND_TAP;
        it.tap_index = TAP_IDX_W'(idx);
        it.coef = COEF_W'(c);
        it.sample = SAMPLE_W'($urandom);
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_item sample_item(logic [SAMPLE_W-1:0] v, bit last);
        t_item it;
        it.kind = KIND_SAMPLE;
        it.tap_index = TAP_IDX_W'($urandom);
        it.coef = COEF_W'($urandom);
        it.sample = v;
        it.last = last;
        return it;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) predict_item(pending_q.pop_front());
        if (!i_rst_n || (s_axis_tvalid && !s_axis_tready)) begin
        end else if (pending_q.size() != 0 && (quiet_in > 0 || $urandom_range(0, 99) >= 16)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= pending_q[0].kind;
            s_axis_tlast  <= pending_q[0].last;
            s_axis_tdata  <= {pending_q[0].sample, pending_q[0].coef, pending_q[0].tap_index};
        end else begin
            s_axis_tvalid <= 1'b0;
        end
        if (quiet_in > 0) quiet_in <= quiet_in - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_smooth e;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer %h", m_axis_tdata);
            end else begin
                e = expected_q.pop_front();
                if (m_axis_tdata[23:0] !== e.smoothed || m_axis_tdata[35:24] !== e.position
                    || m_axis_tdata[39:36] !== 4'd0
                    || m_axis_tuser !== e.zero_sum || m_axis_tlast !== e.last_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp y=%h p=%0d z=%b l=%b got y=%h p=%0d z=%b l=%b",
                                 e.smoothed, e.position, e.zero_sum, e.last_out,
                                 m_axis_tdata[23:0], m_axis_tdata[35:24], m_axis_tuser,
                                 m_axis_tlast);
                end
            end
        end
        m_axis_tready <= i_rst_n && (quiet_out > 0 || $urandom_range(0, 99) >= 16);
        if (quiet_out > 0) quiet_out <= quiet_out - 1;
        if (cycles > 3_000_000) begin
            $display("edge_clamped_normalized_convolver verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_taps(int unsigned tc);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= CFG_W'(tc);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tap_count_reg = tc;
    endtask

    task automatic load_kernel(int k, int mode);
        for (int j = 0; j < k; j++) begin
            case (mode)
                0: pending_q.push_back(tap_item(j, $urandom_range(0, 262143)));
                1: pending_q.push_back(tap_item(j, 0));
                2: pending_q.push_back(tap_item(j, 262143));
                default: pending_q.push_back(tap_item(j, $urandom_range(0, 4000)));
            endcase
        end
    endtask

    task automatic queue_column(int len, int mode);
        logic [SAMPLE_W-1:0] v;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: v = SAMPLE_W'($urandom);
                1: v = (i % 2) ? 24'h7FFFFF : 24'h800000;
                default: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            endcase
            pending_q.push_back(sample_item(v, i == len - 1));
        end
    endtask

    initial begin
        int settings[6];
        int k, sent, len;
        settings = '{1, 63, 2, 0, 8, 17};
        tap_count_reg = 1;
        col_len = 0;
        out_next = 0;
        col_k = 1;
        edge_lo = '0;
        foreach (kernel[i]) kernel[i] = '0;
        foreach (window[i]) window[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: all taps written before any read
        write_taps(63);
        load_kernel(63, 2);
        pending_q.push_back(tap_item(63, 12345));
        queue_column(5, 1);
        queue_column(1, 0);
        queue_column(3, 2);
        wait_drained();
        write_taps(0);
        queue_column(3, 0);
        wait_drained();
        write_taps(3);
        load_kernel(3, 1);
        queue_column(4, 0);
        wait_drained();
        sent = 0;
        while (sent < 377) begin
            foreach (settings[s]) begin
                if (sent >= 377) break;
                write_taps(settings[s] == 8 ? $urandom_range(1, 63) : settings[s]);
                k = tap_count_reg;
                if (s == 2) begin
                    quiet_in = 600;
                    quiet_out = 600;
                end
                load_kernel(k, $urandom_range(0, 3));
                sent += k;
                for (int c = 0; c < 3; c++) begin
                    len = $urandom_range(1, 12);
                    queue_column(len, $urandom_range(0, 4) == 0 ? 2 : 0);
                    sent += len;
                    if ($urandom_range(0, 2) == 0) begin
                        pending_q.push_back(tap_item($urandom_range(0, 63),
                                                     $urandom_range(0, 262143)));
                        sent++;
                    end
                end
                wait_drained();
            end
        end
        if (mismatches == 0)
            $display("edge_clamped_normalized_convolver verification clean");
        else
            $display("edge_clamped_normalized_convolver verification failed");
        $finish;
    end
endmodule
`default_nettype wire
